// ===== hdl/line_seal_encoder_top_defines.svh =====
// Assertion helpers used by the checked module.
`ifndef LINE_SEAL_ENCODER_TOP_DEFINES_SVH
`define LINE_SEAL_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LSE_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LSE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lse_pkg.sv =====
package lse_pkg;

	localparam int unsigned BLOCK_BYTES = 12;
	localparam int unsigned KEY_LEN     = 50;

	localparam logic [7:0] CH_SOH   = 8'h18;
	localparam logic [7:0] CH_EOM   = 8'h19;
	localparam logic [7:0] CH_PAD   = 8'h31;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_HIGH  = 8'h80;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] SEAL_SUB = 8'd32;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        end_of_line;
		logic [23:0] stamp_ms;
	} line_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} seal_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'd0,
		S_DATA  = 4'd1,
		S_SOH   = 4'd2,
		S_CONV  = 4'd3,
		S_SKIP  = 4'd4,
		S_DIGIT = 4'd5,
		S_EOM   = 4'd6,
		S_PAD   = 4'd7,
		S_C80   = 4'd8,
		S_C0A   = 4'd9,
		S_FLUSH = 4'd10
	} step_t;

	typedef enum logic [2:0] {
		P_NONE, P_DATA, P_SOH, P_DIGIT, P_EOM, P_PAD
	} push_t;

	typedef enum logic [1:0] {
		E_NONE, E_SEAL, E_C80, E_C0A
	} emit_t;

	typedef enum logic [3:0] {
		C_NEVER, C_ALWAYS, C_NO_IN, C_NOT_EOL, C_ITER,
		C_LEAD0, C_MORE_DIG, C_FILL_NZ, C_FLUSH_MORE
	} cond_t;

	typedef struct packed {
		push_t push;
		emit_t emit;
		cond_t cond;
		step_t target;
		logic  ret;
		logic  clr_key;
	} ctl_t;

	function automatic ctl_t ctl_rom(step_t s);
		ctl_t c;
		c = '{push: P_NONE, emit: E_NONE, cond: C_NEVER, target: S_IDLE,
			ret: 1'b0, clr_key: 1'b0};
		unique case (s)
			S_IDLE: begin
				c.cond   = C_NO_IN;
				c.target = S_IDLE;
			end
			S_DATA: begin
				c.push   = P_DATA;
				c.cond   = C_NOT_EOL;
				c.target = S_IDLE;
			end
			S_SOH: begin
				c.push = P_SOH;
			end
			S_CONV: begin
				c.cond   = C_ITER;
				c.target = S_CONV;
			end
			S_SKIP: begin
				c.cond   = C_LEAD0;
				c.target = S_SKIP;
			end
			S_DIGIT: begin
				c.push   = P_DIGIT;
				c.cond   = C_MORE_DIG;
				c.target = S_DIGIT;
			end
			S_EOM: begin
				c.push = P_EOM;
			end
			S_PAD: begin
				c.push   = P_PAD;
				c.cond   = C_FILL_NZ;
				c.target = S_PAD;
			end
			S_C80: begin
				c.emit = E_C80;
			end
			S_C0A: begin
				c.emit    = E_C0A;
				c.cond    = C_ALWAYS;
				c.target  = S_IDLE;
				c.clr_key = 1'b1;
			end
			S_FLUSH: begin
				c.emit   = E_SEAL;
				c.cond   = C_FLUSH_MORE;
				c.target = S_FLUSH;
				c.ret    = 1'b1;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

	function automatic logic [3:0] slot_order(logic [3:0] i);
		logic [3:0] r;
		case (i)
			4'd0:    r = 4'd11;
			4'd2:    r = 4'd9;
			4'd4:    r = 4'd7;
			4'd7:    r = 4'd4;
			4'd9:    r = 4'd2;
			4'd11:   r = 4'd0;
			default: r = i;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] seal_key(logic [5:0] p);
		logic [7:0] k;
		case (p)
			6'd0:  k = 8'h54; 6'd1:  k = 8'h69; 6'd2:  k = 8'h6D; 6'd3:  k = 8'h65;
			6'd4:  k = 8'h73; 6'd5:  k = 8'h74; 6'd6:  k = 8'h61; 6'd7:  k = 8'h6D;
			6'd8:  k = 8'h70; 6'd9:  k = 8'h20; 6'd10: k = 8'h28; 6'd11: k = 8'h46;
			6'd12: k = 8'h49; 6'd13: k = 8'h43; 6'd14: k = 8'h53; 6'd15: k = 8'h29;
			6'd16: k = 8'h20; 6'd17: k = 8'h76; 6'd18: k = 8'h31; 6'd19: k = 8'h2E;
			6'd20: k = 8'h30; 6'd21: k = 8'h20; 6'd22: k = 8'h2D; 6'd23: k = 8'h20;
			6'd24: k = 8'h70; 6'd25: k = 8'h72; 6'd26: k = 8'h6F; 6'd27: k = 8'h67;
			6'd28: k = 8'h72; 6'd29: k = 8'h61; 6'd30: k = 8'h6D; 6'd31: k = 8'h6D;
			6'd32: k = 8'h65; 6'd33: k = 8'h64; 6'd34: k = 8'h20; 6'd35: k = 8'h62;
			6'd36: k = 8'h79; 6'd37: k = 8'h20; 6'd38: k = 8'h48; 6'd39: k = 8'h65;
			6'd40: k = 8'h6E; 6'd41: k = 8'h72; 6'd42: k = 8'h69; 6'd43: k = 8'h6B;
			6'd44: k = 8'h20; 6'd45: k = 8'h47; 6'd46: k = 8'h72; 6'd47: k = 8'h61;
			6'd48: k = 8'h6D; 6'd49: k = 8'h2E;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/line_seal_encoder_top.sv =====
// Line sealing encoder.
// line channel (line_valid, line_stall, line_data): one request per byte of a text
//   line; the request with end_of_line set carries stamp_ms and may carry no byte.
// seal channel (seal_valid, seal_stall, seal_data): sealed message bytes, with
//   out_last set on the closing line feed.
// Every request is taken in the idle step only, and a plain byte then takes the idle
//   and push steps. A byte that completes a 12-byte block starts the flush of its
//   12 bytes, one sealed byte per cycle while the output is not stalled.
// The final request runs the trailer: one push step, one start mark step, the
//   binary-to-decimal shifting, the leading-zero skip and digit pushes, one end
//   mark step, the pad pushes that complete the last block, a flush for every
//   completed block and the two closing bytes.
// The rate is set by the microcode sequencer, which runs one control word per cycle
//   while no output step holds, and drives at most one push or output byte per step.
// A single output register holds the pending byte; while seal_stall is high the
//   steps that output bytes hold, pushes and decimal conversion go on.
// Reset clears the step counter, block fill, key position and output valid;
//   the block store holds no meaning until written.
`include "line_seal_encoder_top_defines.svh"

module line_seal_encoder_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           line_valid,
	output logic           line_stall,
	input  lse_pkg::line_t line_data,
	output logic           seal_valid,
	input  logic           seal_stall,
	output lse_pkg::seal_t seal_data
);

	lse_pkg::step_t pc_q;
	lse_pkg::step_t ret_q;
	lse_pkg::step_t next_step;
	lse_pkg::step_t seq_step;
	lse_pkg::ctl_t  ctl;

	logic [7:0]  store_q [lse_pkg::BLOCK_BYTES];
	logic [3:0]  fill_q;
	logic [5:0]  key_q;
	logic [3:0]  fcnt_q;
	logic [4:0]  iter_q;
	logic [2:0]  dig_q;
	logic [31:0] bcd_q;
	logic [23:0] bin_q;
	logic [7:0]  data_q;
	logic        has_q;
	logic        eol_q;
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        olast_q;

	logic        in_acc;
	logic        out_busy;
	logic        hold;
	logic        cond_true;
	logic        push_en;
	logic [7:0]  push_byte;
	logic        emit_en;
	logic [7:0]  emit_byte;
	logic [3:0]  cur_digit;
	logic [31:0] bcd_adj;
	logic [7:0]  flush_src;

	assign ctl        = lse_pkg::ctl_rom(pc_q);
	assign line_stall = (pc_q != lse_pkg::S_IDLE);
	assign in_acc     = line_valid && !line_stall;
	assign out_busy   = ovalid_q && seal_stall;
	assign hold       = (ctl.emit != lse_pkg::E_NONE) && out_busy;
	assign cur_digit  = bcd_q[{dig_q, 2'b00} +: 4];
	assign flush_src  = store_q[lse_pkg::slot_order(fcnt_q)];

	always_comb begin
		for (int d = 0; d < 8; d++) begin
			bcd_adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ?
				bcd_q[d*4 +: 4] + 4'd3 : bcd_q[d*4 +: 4];
		end
	end

	always_comb begin
		case (ctl.cond)
			lse_pkg::C_ALWAYS:     cond_true = 1'b1;
			lse_pkg::C_NO_IN:      cond_true = !in_acc;
			lse_pkg::C_NOT_EOL:    cond_true = !eol_q;
			lse_pkg::C_ITER:       cond_true = (iter_q != 5'd0);
			lse_pkg::C_LEAD0:      cond_true = (dig_q != 3'd0) && (cur_digit == 4'd0);
			lse_pkg::C_MORE_DIG:   cond_true = (dig_q != 3'd0);
			lse_pkg::C_FILL_NZ:    cond_true = (fill_q != 4'd0);
			lse_pkg::C_FLUSH_MORE: cond_true = (fcnt_q != 4'd11);
			default:               cond_true = 1'b0;
		endcase
	end

	always_comb begin
		push_en   = 1'b0;
		push_byte = data_q;
		unique case (ctl.push)
			lse_pkg::P_DATA: begin
				push_en = has_q;
			end
			lse_pkg::P_SOH: begin
				push_en   = 1'b1;
				push_byte = lse_pkg::CH_SOH;
			end
			lse_pkg::P_DIGIT: begin
				push_en   = 1'b1;
				push_byte = lse_pkg::CH_ZERO | {4'd0, cur_digit};
			end
			lse_pkg::P_EOM: begin
				push_en   = 1'b1;
				push_byte = lse_pkg::CH_EOM;
			end
			lse_pkg::P_PAD: begin
				push_en   = (fill_q != 4'd0);
				push_byte = lse_pkg::CH_PAD;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		emit_en   = !out_busy;
		emit_byte = lse_pkg::CH_LF;
		unique case (ctl.emit)
			lse_pkg::E_SEAL: begin
				emit_byte = ((flush_src | lse_pkg::CH_HIGH) ^ lse_pkg::seal_key(key_q))
					- lse_pkg::SEAL_SUB;
			end
			lse_pkg::E_C80: begin
				emit_byte = lse_pkg::CH_HIGH;
			end
			lse_pkg::E_C0A: begin
				emit_byte = lse_pkg::CH_LF;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (cond_true) begin
			next_step = ctl.target;
		end else if (ctl.ret) begin
			next_step = ret_q;
		end else begin
			next_step = lse_pkg::step_t'(pc_q + 4'd1);
		end
		seq_step = (push_en && fill_q == 4'd11) ? lse_pkg::S_FLUSH : next_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= lse_pkg::S_IDLE;
			ret_q    <= lse_pkg::S_IDLE;
			fill_q   <= 4'd0;
			key_q    <= 6'd0;
			fcnt_q   <= 4'd0;
			iter_q   <= 5'd0;
			dig_q    <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (!out_busy) begin
				ovalid_q <= emit_en;
			end
			if (in_acc) begin
				iter_q <= 5'd23;
				dig_q  <= 3'd7;
			end
			if (!hold) begin
				pc_q <= seq_step;
				if (push_en) begin
					fill_q <= (fill_q == 4'd11) ? 4'd0 : fill_q + 4'd1;
					if (fill_q == 4'd11) begin
						ret_q <= next_step;
					end
				end
				if (ctl.cond == lse_pkg::C_ITER && iter_q != 5'd0) begin
					iter_q <= iter_q - 5'd1;
				end
				if ((ctl.cond == lse_pkg::C_LEAD0 || ctl.cond == lse_pkg::C_MORE_DIG)
						&& cond_true) begin
					dig_q <= dig_q - 3'd1;
				end
				if (ctl.emit == lse_pkg::E_SEAL) begin
					fcnt_q <= (fcnt_q == 4'd11) ? 4'd0 : fcnt_q + 4'd1;
					key_q  <= (key_q == 6'd49) ? 6'd0 : key_q + 6'd1;
				end
				if (ctl.clr_key) begin
					key_q  <= 6'd0;
					fill_q <= 4'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= line_data.data_byte;
			has_q  <= line_data.has_byte;
			eol_q  <= line_data.end_of_line;
			bin_q  <= line_data.stamp_ms;
			bcd_q  <= 32'd0;
		end
		if (ctl.cond == lse_pkg::C_ITER) begin
			bcd_q <= {bcd_adj[30:0], bin_q[23]};
			bin_q <= {bin_q[22:0], 1'b0};
		end
		if (push_en) begin
			store_q[fill_q] <= push_byte;
		end
		if (emit_en) begin
			obyte_q <= emit_byte;
			olast_q <= (ctl.emit == lse_pkg::E_C0A);
		end
	end

	assign seal_valid         = ovalid_q;
	assign seal_data.out_byte = obyte_q;
	assign seal_data.out_last = olast_q;

	`LSE_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= 4'd11, "block fill out of range")
	`LSE_ASSERT_NOW(a_last_key, seal_valid && seal_data.out_last, key_q == 6'd0, "key not cleared")
	`LSE_ASSERT_NOW(a_fcnt_flush, fcnt_q != 4'd0, pc_q == lse_pkg::S_FLUSH, "stray flush count")
	`LSE_ASSERT_NEXT(a_accept_step, in_acc, pc_q == lse_pkg::S_DATA, "request not started")

endmodule
